// ===== rtl/core/rrsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rrsp_pkg;

    localparam int MaxRays       = 6;
    localparam int AngleFracBits = 4;
    localparam int DegW          = 9;
    localparam int AngleW        = 13;
    localparam int ColorW        = 24;
    localparam int CfgW          = 48;
    localparam int RayCntW       = 3;
    localparam int StepW         = 4;

    localparam logic [DegW-1:0]   FullTurnDeg = DegW'(360);
    localparam logic [AngleW-1:0] FullTurnFix = AngleW'(360 << AngleFracBits);

    localparam logic [1:0] OpPixel      = 2'd0;
    localparam logic [1:0] OpFrameStart = 2'd1;
    localparam logic [1:0] OpFrameEnd   = 2'd2;

    localparam logic [2:0] CfgRayCount  = 3'd0;
    localparam logic [2:0] CfgStep      = 3'd1;
    localparam logic [2:0] CfgClockwise = 3'd2;
    localparam logic [2:0] CfgSpotlight = 3'd3;
    localparam logic [2:0] CfgColorsA   = 3'd4;
    localparam logic [2:0] CfgColorsB   = 3'd5;
    localparam logic [2:0] CfgColorsC   = 3'd6;

    typedef struct packed {
        logic [RayCntW-1:0] ray_count;
        logic [StepW-1:0]   step_degrees;
        logic               turn_clockwise;
        logic               spotlight_mode;
        logic [CfgW-1:0]    ray_colors_a;
        logic [CfgW-1:0]    ray_colors_b;
        logic [CfgW-1:0]    ray_colors_c;
    } t_cfg;

    // offset of ray i for n rays, i * 360 / n
    function automatic logic [DegW-1:0] ray_offset(input logic [RayCntW-1:0] n,
                                                   input logic [RayCntW-1:0] i);
        logic [DegW-1:0] iw;
        logic [DegW-1:0] r;
        iw = DegW'(i);
        unique case (n)
            3'd2:    r = DegW'(iw * DegW'(180));
            3'd3:    r = DegW'(iw * DegW'(120));
            3'd4:    r = DegW'(iw * DegW'(90));
            3'd5:    r = DegW'(iw * DegW'(72));
            3'd6:    r = DegW'(iw * DegW'(60));
            default: r = '0;
        endcase
        return r;
    endfunction

    // step as signed delta folded into 0..360
    function automatic logic [DegW:0] turn_delta(input logic cw,
                                                 input logic [StepW-1:0] step);
        return cw ? (DegW+1)'(step) : (DegW+1)'(FullTurnDeg) - (DegW+1)'(step);
    endfunction

    function automatic logic [DegW-1:0] wrap_deg(input logic [DegW:0] v);
        return (v >= (DegW+1)'(FullTurnDeg)) ? DegW'(v - (DegW+1)'(FullTurnDeg))
                                             : DegW'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rotating_ray_sweep_painter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rotating ray painter for an LED matrix: a frame start beat latches the frame color,
// each pixel beat (angle in 1/16 degree) is tested against one to six evenly spaced
// rays that sweep step_degrees from the current angle, and a frame end beat moves the
// angle by the step modulo 360. Every beat gives one result beat; a beat is taken each
// cycle while o_in_stall is low, passes an input register and then a result register,
// and all six ray compares sit in the single stage between them.
module rotating_ray_sweep_painter
    import rrsp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [CfgW-1:0]   i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [AngleW-1:0] i_pixel_angle,
    input  wire logic [ColorW-1:0] i_frame_color,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_write_pixel,
    output logic [ColorW-1:0]      o_pixel_color
);

    t_cfg               w_cfg;
    logic               r_in_valid;
    logic [1:0]         r_in_op;
    logic [AngleW-1:0]  r_in_angle;
    logic [ColorW-1:0]  r_in_color;
    logic               r_out_valid;
    logic               r_out_write;
    logic [ColorW-1:0]  r_out_color;
    logic [DegW-1:0]    r_sweep_angle;
    logic [DegW-1:0]    n_sweep_angle;
    logic [ColorW-1:0]  r_latched_color;
    logic               w_advance;
    logic               w_move;
    logic               w_load;
    logic               w_hit;
    logic [ColorW-1:0]  w_color;

    rrsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    rrsp_ray_match u_match (
        .i_angle         (r_in_angle),
        .i_sweep         (r_sweep_angle),
        .i_latched_color (r_latched_color),
        .i_cfg           (w_cfg),
        .o_hit           (w_hit),
        .o_color         (w_color)
    );

    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_move     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_load     = i_in_valid && !o_in_stall;

    assign n_sweep_angle = wrap_deg({1'b0, r_sweep_angle} +
                                    turn_delta(w_cfg.turn_clockwise, w_cfg.step_degrees));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_sweep_angle   <= '0;
            r_latched_color <= '0;
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_move) begin
                r_in_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_move && r_in_op == OpFrameStart) begin
                r_latched_color <= r_in_color;
            end
            if (w_move && r_in_op == OpFrameEnd) begin
                r_sweep_angle <= n_sweep_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_op    <= i_operation;
            r_in_angle <= i_pixel_angle;
            r_in_color <= i_frame_color;
        end
        if (w_move) begin
            r_out_write <= (r_in_op == OpPixel) && w_hit;
            r_out_color <= (r_in_op == OpPixel) ? w_color : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_pixel = r_out_write;
    assign o_pixel_color = r_out_color;

`ifndef SYNTHESIS
    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> r_sweep_angle < FullTurnDeg)
        else $error("sweep angle out of range");

    a_sweep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_move && r_in_op == OpFrameEnd) |=> $stable(r_sweep_angle))
        else $error("sweep angle moved without frame end");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid && $stable(r_in_op) && $stable(r_in_angle))
        else $error("input register lost a stalled beat");

    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_pixel |-> o_pixel_color == '0)
        else $error("color set without pixel write");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/rrsp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrsp_cfg
    import rrsp_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ray_count      <= RayCntW'(1);
            r_cfg.step_degrees   <= StepW'(1);
            r_cfg.turn_clockwise <= 1'b1;
            r_cfg.spotlight_mode <= 1'b0;
            r_cfg.ray_colors_a   <= '0;
            r_cfg.ray_colors_b   <= '0;
            r_cfg.ray_colors_c   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgRayCount:  r_cfg.ray_count      <= i_cfg_data[RayCntW-1:0];
                CfgStep:      r_cfg.step_degrees   <= i_cfg_data[StepW-1:0];
                CfgClockwise: r_cfg.turn_clockwise <= i_cfg_data[0];
                CfgSpotlight: r_cfg.spotlight_mode <= i_cfg_data[0];
                CfgColorsA:   r_cfg.ray_colors_a   <= i_cfg_data;
                CfgColorsB:   r_cfg.ray_colors_b   <= i_cfg_data;
                CfgColorsC:   r_cfg.ray_colors_c   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/core/rrsp_ray_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rrsp_ray_match
    import rrsp_pkg::*;
(
    input  wire logic [AngleW-1:0] i_angle,
    input  wire logic [DegW-1:0]   i_sweep,
    input  wire logic [ColorW-1:0] i_latched_color,
    input  wire t_cfg              i_cfg,
    output logic                   o_hit,
    output logic [ColorW-1:0]      o_color
);

    logic [AngleW-1:0]         w_a;
    logic [RayCntW-1:0]        w_n;
    logic [DegW:0]             w_delta;
    logic                      w_incr;
    logic [3*CfgW-1:0]         w_all_colors;
    logic [DegW-1:0]           w_sdeg [MaxRays];
    logic [DegW-1:0]           w_edeg [MaxRays];
    logic [AngleW-1:0]         w_s    [MaxRays];
    logic [AngleW-1:0]         w_e    [MaxRays];
    logic [MaxRays-1:0]        w_arc;
    logic [MaxRays-1:0]        w_hit;
    logic [ColorW-1:0]         w_color;

    assign w_a = (i_angle >= FullTurnFix) ? i_angle - FullTurnFix : i_angle;

    always_comb begin
        if (i_cfg.ray_count == '0) begin
            w_n = RayCntW'(1);
        end else if (i_cfg.ray_count > RayCntW'(MaxRays)) begin
            w_n = RayCntW'(MaxRays);
        end else begin
            w_n = i_cfg.ray_count;
        end
    end

    assign w_delta      = turn_delta(i_cfg.turn_clockwise, i_cfg.step_degrees);
    assign w_incr       = i_cfg.turn_clockwise && (i_cfg.step_degrees != '0);
    assign w_all_colors = {i_cfg.ray_colors_c, i_cfg.ray_colors_b, i_cfg.ray_colors_a};

    always_comb begin
        for (int i = 0; i < MaxRays; i++) begin
            w_sdeg[i] = wrap_deg({1'b0, i_sweep} +
                                 {1'b0, ray_offset(w_n, RayCntW'(i))});
            w_edeg[i] = wrap_deg({1'b0, w_sdeg[i]} + w_delta);
            w_s[i]    = AngleW'(w_sdeg[i]) << AngleFracBits;
            w_e[i]    = AngleW'(w_edeg[i]) << AngleFracBits;
            if (w_incr) begin
                w_arc[i] = (w_s[i] <= w_e[i]) ? (w_a >= w_s[i] && w_a <= w_e[i])
                                              : (w_a >= w_s[i] || w_a <= w_e[i]);
            end else begin
                w_arc[i] = (w_e[i] <= w_s[i]) ? (w_a >= w_e[i] && w_a <= w_s[i])
                                              : (w_a >= w_e[i] || w_a <= w_s[i]);
            end
            w_hit[i] = w_arc[i] && (RayCntW'(i) < w_n);
        end
    end

    // highest matching ray wins in spotlight mode
    always_comb begin
        w_color = i_latched_color;
        if (i_cfg.spotlight_mode) begin
            for (int i = 0; i < MaxRays; i++) begin
                if (w_hit[i]) begin
                    w_color = w_all_colors[i*ColorW +: ColorW];
                end
            end
        end
    end

    assign o_hit   = |w_hit;
    assign o_color = o_hit ? w_color : '0;

endmodule
`default_nettype wire
